FILE: hw/rtl/esc_pkg.sv
package esc_pkg;

   // Calendar constants
   localparam logic [11:0] EPOCH_YEAR     = 12'd1970;
   localparam logic [1:0]  EPOCH_MOD4     = 2'd2;     // 1970 mod 4
   localparam logic [6:0]  EPOCH_MOD100   = 7'd70;    // 1970 mod 100
   localparam logic [8:0]  EPOCH_MOD400   = 9'd370;   // 1970 mod 400
   localparam logic [6:0]  CENTURY_LAST   = 7'd99;
   localparam logic [8:0]  QUADCENT_LAST  = 9'd399;
   localparam logic [15:0] DAYS_YEAR      = 16'd365;
   localparam logic [15:0] DAYS_LEAP_YEAR = 16'd366;
   localparam logic [15:0] MONTH_MIN_DAYS = 16'd28;
   localparam logic [3:0]  MONTHS         = 4'd12;

   // Reciprocals, rounded up; exact quotient over the operand range used
   localparam logic [29:0] MS_RECIP       = 30'd549755814;  // 2^36 / 125, on ms >> 3
   localparam logic [25:0] DAY_RECIP      = 26'd50903317;   // 2^35 / 675, on secs >> 7
   localparam logic [16:0] SECS_PER_DAY   = 17'd86400;
   localparam logic [13:0] HOUR_RECIP     = 14'd9321;       // 2^21 / 225, on tod >> 4
   localparam logic [11:0] SECS_PER_HOUR  = 12'd3600;
   localparam logic [10:0] MIN_RECIP      = 11'd1093;       // 2^14 / 15, on rest >> 2
   localparam logic [5:0]  SECS_PER_MIN   = 6'd60;
   localparam logic [3:0]  HMS_STEPS      = 4'd4;

   // Configuration registers
   localparam int          CSR_IDX_W        = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_SECONDS = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_TICK    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ZONE_OFFSET  = 8'd2;
   localparam logic [16:0] ZONE_RESET     = 17'd28800;

   // Queue between front and back
   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef struct packed {
      logic [31:0] base_seconds;
      logic [31:0] base_tick;
      logic [16:0] zone_offset;
   } csr_type;

   // Whole days since epoch and second of day
   typedef struct packed {
      logic [15:0] days;
      logic [16:0] tod;
   } day_split_type;

   function automatic logic is_leap(input logic [1:0] m4, input logic [6:0] m100,
                                    input logic [8:0] m400);
      is_leap = ((m4 == 2'd0) && (m100 != 7'd0)) || (m400 == 9'd0);
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] mon, input logic leap);
      case (mon)
         4'd0:    month_days = 5'd31;
         4'd1:    month_days = leap ? 5'd29 : 5'd28;
         4'd2:    month_days = 5'd31;
         4'd3:    month_days = 5'd30;
         4'd4:    month_days = 5'd31;
         4'd5:    month_days = 5'd30;
         4'd6:    month_days = 5'd31;
         4'd7:    month_days = 5'd31;
         4'd8:    month_days = 5'd30;
         4'd9:    month_days = 5'd31;
         4'd10:   month_days = 5'd30;
         4'd11:   month_days = 5'd31;
         default: month_days = 5'd31;
      endcase
   endfunction

endpackage

FILE: hw/rtl/epoch_seconds_to_calendar.sv
// Channel   Handshake                  Word
// -------   -------------------------  ----------------------------------------
// request   start / busy               req_tick_now
// response  rsp_strobe (one cycle)     rsp_year, rsp_month, rsp_day_of_month,
//                                      rsp_hour, rsp_minute, rsp_second
// csr       csr_valid / csr_ready      csr_index, csr_data
//
// Front: subtract, divide by 1000, add, divide by 86400, day remainder, push;
// busy from accept until the push is taken, held while the two-word queue is full.
// Back: pop, year walk, month walk, finish; the hour/minute split takes four
// steps beside the walks. Sustained rate is set by the back year walk.
// Synchronous active-high reset; csr_ready is always high; receiver cannot stall.
module epoch_seconds_to_calendar import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [31:0]          req_tick_now,
   output logic                 rsp_strobe,
   output logic [11:0]          rsp_year,
   output logic [3:0]           rsp_month,
   output logic [4:0]           rsp_day_of_month,
   output logic [4:0]           rsp_hour,
   output logic [5:0]           rsp_minute,
   output logic [5:0]           rsp_second,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data
);

   logic [31:0]   base_seconds_ff;
   logic [31:0]   base_tick_ff;
   logic [16:0]   zone_offset_ff;
   csr_type       csr;
   logic          q_full, q_empty, q_push, q_pop;
   day_split_type q_wr_data, q_rd_data;

   // Configuration registers; unknown index is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_seconds_ff <= '0;
         base_tick_ff    <= '0;
         zone_offset_ff  <= ZONE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BASE_SECONDS: base_seconds_ff <= csr_data;
            CSR_BASE_TICK:    base_tick_ff    <= csr_data;
            CSR_ZONE_OFFSET:  zone_offset_ff  <= csr_data[16:0];
            default: begin
            end
         endcase
      end
   end

   assign csr = '{base_seconds: base_seconds_ff, base_tick: base_tick_ff,
                  zone_offset: zone_offset_ff};

   esc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr),
      .start    (start),
      .busy     (busy),
      .tick_now (req_tick_now),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_data   (q_wr_data)
   );

   esc_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .full    (q_full),
      .empty   (q_empty)
   );

   esc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_empty          (q_empty),
      .q_data           (q_rd_data),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second)
   );

endmodule

FILE: hw/rtl/esc_front.sv
module esc_front import esc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  csr_type       csr,
   input  logic          start,
   output logic          busy,
   input  logic [31:0]   tick_now,
   input  logic          q_full,
   output logic          q_push,
   output day_split_type q_data
);

   localparam logic [2:0] FS_IDLE   = 3'd0;
   localparam logic [2:0] FS_DIVMS  = 3'd1;
   localparam logic [2:0] FS_SUM    = 3'd2;
   localparam logic [2:0] FS_DIVDAY = 3'd3;
   localparam logic [2:0] FS_TOD    = 3'd4;
   localparam logic [2:0] FS_PUSH   = 3'd5;

   logic [2:0]  state_ff, state_in;
   logic [31:0] num_ff, num_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] rem_ff, rem_in;

   logic [58:0] ms_prod;
   logic [50:0] day_prod;
   logic [32:0] day_base;
   logic [31:0] tod_full;
   logic [31:0] secs;

   // Elapsed ms / 1000 as (ms >> 3) / 125
   assign ms_prod  = num_ff[31:3] * MS_RECIP;
   // Seconds / 86400 as (secs >> 7) / 675
   assign day_prod = num_ff[31:7] * DAY_RECIP;
   // Second of day: seconds less the start of that day
   assign day_base = days_ff * SECS_PER_DAY;
   assign tod_full = num_ff - day_base[31:0];

   // Wrapping sum of base, elapsed seconds and sign-extended zone offset
   assign secs = csr.base_seconds + num_ff + {{15{csr.zone_offset[16]}}, csr.zone_offset};

   assign busy   = (state_ff != FS_IDLE);
   assign q_push = (state_ff == FS_PUSH) && !q_full;
   assign q_data = '{days: days_ff, tod: rem_ff};

   always_comb begin
      state_in = state_ff;
      num_in   = num_ff;
      days_in  = days_ff;
      rem_in   = rem_ff;
      case (state_ff)
         FS_IDLE: begin
            if (start) begin
               num_in   = tick_now - csr.base_tick;
               state_in = FS_DIVMS;
            end
         end
         FS_DIVMS: begin
            num_in   = {9'd0, ms_prod[58:36]};
            state_in = FS_SUM;
         end
         FS_SUM: begin
            num_in   = secs;
            state_in = FS_DIVDAY;
         end
         FS_DIVDAY: begin
            days_in  = day_prod[50:35];
            state_in = FS_TOD;
         end
         FS_TOD: begin
            rem_in   = tod_full[16:0];
            state_in = FS_PUSH;
         end
         FS_PUSH: begin
            if (!q_full) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff  <= num_in;
      days_ff <= days_in;
      rem_ff  <= rem_in;
   end

endmodule

FILE: hw/rtl/esc_fifo.sv
module esc_fifo import esc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  day_split_type wr_data,
   input  logic          pop,
   output day_split_type rd_data,
   output logic          full,
   output logic          empty
);

   day_split_type     mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_push, do_pop;

   function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
      ptr_next = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign full    = (count_ff == QCNT_W'(QDEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= ptr_next(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= ptr_next(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/esc_back.sv
module esc_back import esc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_empty,
   input  day_split_type q_data,
   output logic          q_pop,
   output logic          rsp_strobe,
   output logic [11:0]   rsp_year,
   output logic [3:0]    rsp_month,
   output logic [4:0]    rsp_day_of_month,
   output logic [4:0]    rsp_hour,
   output logic [5:0]    rsp_minute,
   output logic [5:0]    rsp_second
);

   localparam logic [1:0] BS_IDLE   = 2'd0;
   localparam logic [1:0] BS_YEAR   = 2'd1;
   localparam logic [1:0] BS_MONTH  = 2'd2;
   localparam logic [1:0] BS_FINISH = 2'd3;

   localparam logic [3:0] HS_HOUR       = 4'd0;
   localparam logic [3:0] HS_HOUR_SUB   = 4'd1;
   localparam logic [3:0] HS_MINUTE     = 4'd2;
   localparam logic [3:0] HS_MINUTE_SUB = 4'd3;

   logic [1:0]  state_ff, state_in;
   logic [15:0] days_ff, days_in;
   logic [11:0] year_ff, year_in;
   logic [1:0]  m4_ff, m4_in;
   logic [6:0]  m100_ff, m100_in;
   logic [8:0]  m400_ff, m400_in;
   logic [3:0]  mon_ff, mon_in;
   logic [16:0] tod_ff, tod_in;
   logic [3:0]  step_ff, step_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;

   logic        strobe_ff, strobe_in;
   logic [11:0] out_year_ff;
   logic [3:0]  out_month_ff;
   logic [4:0]  out_day_ff;
   logic [4:0]  out_hour_ff;
   logic [5:0]  out_minute_ff;
   logic [5:0]  out_second_ff;

   logic        leap;
   logic [15:0] mlen;
   logic        hms_done;
   logic [26:0] hour_prod;
   logic [16:0] hour_base;
   logic [20:0] min_prod;
   logic [11:0] min_base;

   assign leap     = is_leap(m4_ff, m100_ff, m400_ff);
   assign mlen     = {11'd0, month_days(mon_ff, leap)};
   assign hms_done = (step_ff == HMS_STEPS);
   assign q_pop    = (state_ff == BS_IDLE) && !q_empty;

   // tod / 3600 as (tod >> 4) / 225, rest / 60 as (rest >> 2) / 15
   assign hour_prod = tod_ff[16:4] * HOUR_RECIP;
   assign hour_base = hour_ff * SECS_PER_HOUR;
   assign min_prod  = tod_ff[11:2] * MIN_RECIP;
   assign min_base  = minute_ff * SECS_PER_MIN;

   // Year walk, month walk and hour/minute split
   always_comb begin
      state_in  = state_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      m4_in     = m4_ff;
      m100_in   = m100_ff;
      m400_in   = m400_ff;
      mon_in    = mon_ff;
      tod_in    = tod_ff;
      step_in   = step_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      strobe_in = 1'b0;

      // time of day in four steps, runs beside the walks; tod ends as the second
      if (state_ff != BS_IDLE && !hms_done) begin
         case (step_ff)
            HS_HOUR:       hour_in   = hour_prod[25:21];
            HS_HOUR_SUB:   tod_in    = tod_ff - hour_base;
            HS_MINUTE:     minute_in = min_prod[19:14];
            HS_MINUTE_SUB: tod_in    = tod_ff - {5'd0, min_base};
            default: begin
            end
         endcase
         step_in = step_ff + 4'd1;
      end

      case (state_ff)
         BS_IDLE: begin
            if (!q_empty) begin
               days_in   = q_data.days;
               tod_in    = q_data.tod;
               year_in   = EPOCH_YEAR;
               m4_in     = EPOCH_MOD4;
               m100_in   = EPOCH_MOD100;
               m400_in   = EPOCH_MOD400;
               step_in   = '0;
               hour_in   = '0;
               minute_in = '0;
               state_in  = BS_YEAR;
            end
         end
         BS_YEAR: begin
            if (days_ff >= DAYS_YEAR && (!leap || days_ff >= DAYS_LEAP_YEAR)) begin
               days_in = days_ff - (leap ? DAYS_LEAP_YEAR : DAYS_YEAR);
               year_in = year_ff + 12'd1;
               m4_in   = m4_ff + 2'd1;
               m100_in = (m100_ff == CENTURY_LAST) ? 7'd0 : m100_ff + 7'd1;
               m400_in = (m400_ff == QUADCENT_LAST) ? 9'd0 : m400_ff + 9'd1;
            end else begin
               mon_in   = '0;
               state_in = BS_MONTH;
            end
         end
         BS_MONTH: begin
            if (days_ff >= MONTH_MIN_DAYS && mon_ff < MONTHS && days_ff >= mlen) begin
               days_in = days_ff - mlen;
               mon_in  = mon_ff + 4'd1;
            end else begin
               state_in = BS_FINISH;
            end
         end
         BS_FINISH: begin
            if (hms_done) begin
               strobe_in = 1'b1;
               state_in  = BS_IDLE;
            end
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= BS_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      days_ff   <= days_in;
      year_ff   <= year_in;
      m4_ff     <= m4_in;
      m100_ff   <= m100_in;
      m400_ff   <= m400_in;
      mon_ff    <= mon_in;
      tod_ff    <= tod_in;
      step_ff   <= step_in;
      hour_ff   <= hour_in;
      minute_ff <= minute_in;
   end

   // Result word register
   always_ff @(posedge clock) begin
      if (strobe_in) begin
         out_year_ff   <= year_ff;
         out_month_ff  <= mon_ff + 4'd1;
         out_day_ff    <= days_ff[4:0] + 5'd1;
         out_hour_ff   <= hour_ff;
         out_minute_ff <= minute_ff;
         out_second_ff <= tod_ff[5:0];
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_year         = out_year_ff;
   assign rsp_month        = out_month_ff;
   assign rsp_day_of_month = out_day_ff;
   assign rsp_hour         = out_hour_ff;
   assign rsp_minute       = out_minute_ff;
   assign rsp_second       = out_second_ff;

endmodule

FILE: hw/rtl/esc_checker.sv
module esc_checker import esc_pkg::*; (
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [31:0]          req_tick_now,
   input logic                 rsp_strobe,
   input logic [11:0]          rsp_year,
   input logic [3:0]           rsp_month,
   input logic [4:0]           rsp_day_of_month,
   input logic [4:0]           rsp_hour,
   input logic [5:0]           rsp_minute,
   input logic [5:0]           rsp_second,
   input logic                 csr_valid,
   input logic                 csr_ready,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [31:0]          csr_data
);

   // Reset leaves front idle and no result word pending
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!rsp_strobe && !busy))
      else $error("activity right after reset");

   // An accepted word always keeps the front busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("front not busy after accept");

   // Results never come in adjacent cycles
   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("back-to-back result strobes");

   // Every result word has its fields in range (day of month checked only from below)
   a_fields_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_month >= 4'd1 && rsp_month <= 4'd12 &&
                      rsp_day_of_month >= 5'd1 && rsp_hour <= 5'd23 &&
                      rsp_minute <= 6'd59 && rsp_second <= 6'd59 &&
                      rsp_year >= EPOCH_YEAR))
      else $error("result field out of range");

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

FILE: dv/calendar_checker.sv
module calendar_checker import esc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 busy,
   input  logic [31:0]          req_tick_now,
   input  logic                 rsp_strobe,
   input  logic [11:0]          rsp_year,
   input  logic [3:0]           rsp_month,
   input  logic [4:0]           rsp_day_of_month,
   input  logic [4:0]           rsp_hour,
   input  logic [5:0]           rsp_minute,
   input  logic [5:0]           rsp_second,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_data,
   output int                   outstanding,
   output int                   fail_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] FIRST_YEAR   = 32'd1970;
   localparam logic [31:0] SECS_PER_DAY = 32'd86400;
   localparam logic [31:0] MS_PER_SEC   = 32'd1000;

   typedef struct packed {
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  mday;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
   } cal_word_type;

   // Shadow copy of the clock-setting registers
   logic [31:0] set_seconds;
   logic [31:0] set_tick;
   logic [16:0] zone;

   cal_word_type due_dates[$];
   cal_word_type want;
   int           mismatches = 0;

   assign fail_count = mismatches;

   function automatic bit gregorian_leap(input logic [31:0] y);
      return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
   endfunction

   // Tick count -> local calendar date, all sums mod 2^32
   function automatic cal_word_type epoch_to_date(input logic [31:0] tick);
      cal_word_type w;
      logic [31:0]  elapsed;
      logic [31:0]  secs;
      logic [31:0]  days;
      logic [31:0]  yr;
      logic [31:0]  mon;
      logic [31:0]  mlen;
      bit           leap;
      bit           done;
      elapsed = tick - set_tick;
      secs    = set_seconds + elapsed / MS_PER_SEC + {{15{zone[16]}}, zone};
      days    = secs / SECS_PER_DAY;

      // walk whole years; a leap year needs 366 days left to pass
      yr   = FIRST_YEAR;
      done = 1'b0;
      while (!done && days >= 32'd365) begin
         leap = gregorian_leap(yr);
         if (leap && days < 32'd366) begin
            done = 1'b1;
         end else begin
            days = days - (leap ? 32'd366 : 32'd365);
            yr   = yr + 1;
         end
      end

      // walk months; stops early once under 28 days remain
      leap = gregorian_leap(yr);
      mon  = 0;
      done = 1'b0;
      while (!done && days >= 32'd28 && mon < 32'd12) begin
         if (mon == 1)
            mlen = leap ? 32'd29 : 32'd28;
         else if (mon == 3 || mon == 5 || mon == 8 || mon == 10)
            mlen = 32'd30;
         else
            mlen = 32'd31;
         if (days < mlen) begin
            done = 1'b1;
         end else begin
            days = days - mlen;
            mon  = mon + 1;
         end
      end

      w.year   = yr[11:0];
      w.month  = 4'(mon + 1);
      w.mday   = 5'(days + 1);
      w.hour   = 5'(secs / 32'd3600 % 32'd24);
      w.minute = 6'(secs / 32'd60 % 32'd60);
      w.second = 6'(secs % 32'd60);
      return w;
   endfunction

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] got);
      if (got !== exp_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         set_seconds = '0;
         set_tick    = '0;
         zone        = ZONE_RESET;
         due_dates.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_BASE_SECONDS: set_seconds = csr_data;
               CSR_BASE_TICK:    set_tick    = csr_data;
               CSR_ZONE_OFFSET:  zone        = csr_data[16:0];
               default: ;
            endcase
         end

         // results first: a word accepted this edge cannot be answered yet
         if (rsp_strobe) begin
            if (due_dates.size() == 0) begin
               mismatches++;
               $display("%0t: result word with no date pending, expected none, got %0d-%0d-%0d",
                        $time, rsp_year, rsp_month, rsp_day_of_month);
            end else begin
               want = due_dates.pop_front();
               check_field("year",   32'(want.year),   32'(rsp_year));
               check_field("month",  32'(want.month),  32'(rsp_month));
               check_field("day",    32'(want.mday),   32'(rsp_day_of_month));
               check_field("hour",   32'(want.hour),   32'(rsp_hour));
               check_field("minute", 32'(want.minute), 32'(rsp_minute));
               check_field("second", 32'(want.second), 32'(rsp_second));
            end
         end

         if (start && !busy)
            due_dates.push_back(epoch_to_date(req_tick_now));
      end
      outstanding <= due_dates.size();
   end

endmodule

FILE: dv/testbench.sv
module testbench;
   import esc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          RAND_PHASES     = 8;
   localparam int          ITEMS_PER_PHASE = 75;
   localparam int          SETTLE_CYCLES   = 4;
   localparam int          TAIL_CYCLES     = 300;
   localparam int          CYCLE_LIMIT     = 2_000_000;
   localparam logic [16:0] ZONE_WEST       = -17'sd43200;
   localparam logic [16:0] ZONE_EAST       = 17'd50400;
   localparam logic [16:0] ZONE_UTC        = 17'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_INDEX = '1;

   logic                 clock;
   logic                 reset        = 1'b1;
   logic                 start        = 1'b0;
   logic                 busy;
   logic [31:0]          req_tick_now = '0;
   logic                 rsp_strobe;
   logic [11:0]          rsp_year;
   logic [3:0]           rsp_month;
   logic [4:0]           rsp_day_of_month;
   logic [4:0]           rsp_hour;
   logic [5:0]           rsp_minute;
   logic [5:0]           rsp_second;
   logic                 csr_valid    = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index    = '0;
   logic [31:0]          csr_data     = '0;
   int                   outstanding;
   int                   fail_count;
   int                   cycles       = 0;

   epoch_seconds_to_calendar uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_tick_now     (req_tick_now),
      .rsp_strobe       (rsp_strobe),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   calendar_checker dates_chk (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_tick_now     (req_tick_now),
      .rsp_strobe       (rsp_strobe),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day_of_month (rsp_day_of_month),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .outstanding      (outstanding),
      .fail_count       (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run-away guard
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // All tasks below are entered right after a rising edge.
   task automatic send_tick(input logic [31:0] t, input bit hold);
      start        <= 1'b1;
      req_tick_now <= t;
      do @(posedge clock); while (busy);
      if (!hold)
         start <= 1'b0;
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data,
                            input bit last);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (last)
         csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      do @(posedge clock); while (outstanding != 0 || busy);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // set the clock: base seconds, tick at that moment, zone; junk above bit 16
   task automatic retime(input logic [31:0] bs, input logic [31:0] bt, input logic [16:0] zo);
      logic [31:0] zword;
      zword        = $urandom;
      zword[16:0]  = zo;
      wait_idle();
      csr_write(CSR_BASE_SECONDS, bs, 1'b0);
      csr_write(CSR_BASE_TICK, bt, 1'b0);
      csr_write(CSR_ZONE_OFFSET, zword, 1'b1);
   endtask

   function automatic logic [31:0] next_tick(input logic [31:0] bt);
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return bt + $urandom_range(0, 100_000_000);
         4, 5:       return $urandom;
         6:          return bt - $urandom_range(1, 2_000_000);   // tick behind base: wraps
         7:          return bt + $urandom_range(0, 999);
         default:    return bt + 32'd86_400_000 * $urandom_range(0, 49);
      endcase
   endfunction

   initial begin
      int          sel;
      int          burst_left;
      int          gap;
      logic [31:0] bs;
      logic [31:0] bt;
      logic [16:0] zo;
      logic [31:0] raw;
      bit          last;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset values: zone +8 h, base at zero
      send_tick(32'd0, 1'b1);
      send_tick(32'd57_600_000, 1'b1);
      send_tick(32'hFFFF_FFFF, 1'b0);

      // UTC, edges of the millisecond and day boundaries
      retime(32'd0, 32'd0, ZONE_UTC);
      send_tick(32'd999, 1'b1);
      send_tick(32'd1000, 1'b1);
      send_tick(32'd86_399_999, 1'b1);
      send_tick(32'hFFFF_FFFF, 1'b0);

      // tick below base wraps before the divide
      retime(32'd0, 32'hFFFF_FFFF, ZONE_UTC);
      send_tick(32'd0, 1'b1);
      send_tick(32'hFFFF_FFFE, 1'b0);

      // last representable second, then one more wraps to 1970
      retime(32'hFFFF_FFFF, 32'h1234_5678, ZONE_UTC);
      send_tick(32'h1234_5678, 1'b0);
      retime(32'hFFFF_FFFF, 32'h1234_5678, 17'd1);
      send_tick(32'h1234_5678, 1'b0);

      // western extreme from zero wraps backwards
      retime(32'd0, 32'd0, ZONE_WEST);
      send_tick(32'd0, 1'b0);

      // 2100 is not a leap year: Feb 28 rolls into Mar 1
      retime(32'd4_107_456_000, 32'd0, ZONE_EAST);
      send_tick(32'd0, 1'b1);
      send_tick(32'd36_000_000, 1'b0);

      // 2000 is a leap year
      retime(32'd951_696_000, 32'd0, ZONE_UTC);
      send_tick(32'd0, 1'b1);
      send_tick(32'd86_400_000, 1'b1);
      send_tick(32'd172_800_000, 1'b0);

      // offset patterns outside the stated range, sign-extended
      retime(32'd68_083_200, 32'd0, 17'h1_0000);
      send_tick(32'd65_536_000, 1'b1);
      send_tick(32'd151_936_000, 1'b0);
      retime(32'd978_220_800, 32'd0, 17'h0_FFFF);
      send_tick(32'd0, 1'b0);
      retime(32'd978_307_200, 32'd0, 17'h1_FFFF);
      send_tick(32'd0, 1'b0);

      // writes to unmapped indexes must leave the setting alone
      wait_idle();
      csr_write(CSR_IDX_W'($urandom_range(CSR_ZONE_OFFSET + 1, CSR_TOP_INDEX - 1)),
                $urandom, 1'b0);
      csr_write(CSR_TOP_INDEX, 32'hFFFF_FFFF, 1'b1);
      send_tick(32'd12_345_678, 1'b0);

      // random phases, each with a fresh clock setting
      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         sel = (phase < 2) ? phase : $urandom_range(0, 3);
         case (sel)
            0:       bs = $urandom_range(0, 200_000);
            1:       bs = 32'hFFFF_FFFF - $urandom_range(0, 200_000);
            default: bs = $urandom;
         endcase
         bt  = $urandom;
         sel = (phase < 2) ? phase : $urandom_range(0, 3);
         case (sel)
            0: zo = ZONE_WEST;
            1: zo = ZONE_EAST;
            2: begin
               // anywhere in -12 h .. +14 h
               raw = $urandom_range(0, 93_600) - 32'd43_200;
               zo  = raw[16:0];
            end
            default: begin
               raw = $urandom;
               zo  = raw[16:0];
            end
         endcase
         retime(bs, bt, zo);

         // bursts of back-to-back words, then a short or long gap
         burst_left = $urandom_range(1, 24);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            last       = (n == ITEMS_PER_PHASE - 1);
            burst_left = burst_left - 1;
            gap        = 0;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 260)
                                                 : $urandom_range(0, 8);
            end
            send_tick(next_tick(bt), !last && gap == 0);
            if (!last)
               repeat (gap) @(posedge clock);
         end
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
